// ===== rtl/best_fit_block_allocator_core_assert.svh =====
// assertion helpers for the allocator core; clk and rst must be in scope
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  localparam int SLOTS_DEFAULT        = 16;
  localparam int ADDRESS_BITS_DEFAULT = 16;

  localparam int CFG_W    = 5;
  localparam int MODE_W   = 2;
  localparam int SLOT_F_W = 4;
  localparam int SIZE_W   = 16;
  localparam int ADDR_F_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SLOT_F_W-1:0] slot;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_F_W-1:0] start_address;
  } bfa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_F_W-1:0] chosen_slot;
    logic [ADDR_F_W-1:0] granted_address;
    logic [SIZE_W-1:0]   remaining_size;
  } bfa_out_t;

endpackage

`default_nettype wire

// ===== rtl/bfa_ram.sv =====
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/best_fit_block_allocator_core.sv =====
`default_nettype none

// Best-fit free block allocator. The free list (size and start address per slot) lives in
// one synchronous RAM with a single read and a single write port. A load word writes its
// slot and a read word returns it; an allocate word walks the first min(blocks_in_use,
// SLOTS) slots through the read port, one slot per cycle, keeps the block with the
// smallest leftover (ties to the lower start, then the lower slot), and writes the shrunk
// entry back. The slot walk through the one RAM read port sets the allocate time. The
// finished result sits in an output register, so the next word is taken while a result
// still waits. cfg_data is always accepted; write it only while the core is idle. Slots
// must be loaded before they are read or scanned.

module best_fit_block_allocator_core #(
  parameter int SLOTS        = bfa_pkg::SLOTS_DEFAULT,
  parameter int ADDRESS_BITS = bfa_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bfa_pkg::bfa_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bfa_pkg::bfa_out_t         out_data
);

  import bfa_pkg::*;

  `include "best_fit_block_allocator_core_assert.svh"

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = SIZE_W + ADDRESS_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_SCAN   = 5'b00100,
    S_WB     = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]        blocks_in_use;
  logic [CFG_W-1:0]        scan_count;
  logic [CFG_W-1:0]        scan_last;
  logic [CFG_W-1:0]        cmp_idx;
  logic [SIZE_W-1:0]       req_size;
  logic                    best_found;
  logic [CFG_W-1:0]        best_slot;
  logic [SIZE_W-1:0]       best_left;
  logic [ADDRESS_BITS-1:0] best_start;
  bfa_out_t                res;

  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [SLOT_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic [SIZE_W-1:0]       e_size;
  logic [ADDRESS_BITS-1:0] e_start;
  logic [SIZE_W-1:0]       e_left;
  logic                    fits;
  logic                    take;
  logic                    in_range;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      blocks_in_use <= cfg_data;
    end
  end

  // a count above the table depth scans the whole table
  assign scan_count = (32'(blocks_in_use) > SLOTS) ? CFG_W'(SLOTS) : blocks_in_use;
  assign in_range   = (32'(in_data.slot) < SLOTS);

  assign e_size  = ram_rdata[ENTRY_W-1 -: SIZE_W];
  assign e_start = ram_rdata[ADDRESS_BITS-1:0];
  assign fits    = (e_size >= req_size);
  assign e_left  = e_size - req_size;
  assign take    = fits && (!best_found || (e_left < best_left) ||
                            ((e_left == best_left) && (e_start < best_start)));

  always_comb begin
    ram_we = ((state == S_IDLE) && in_valid && (in_data.mode == MODE_LOAD) && in_range) ||
             ((state == S_WB) && best_found);
    if (state == S_WB) begin
      ram_waddr = SLOT_W'(best_slot);
      ram_wdata = {best_left, best_start + ADDRESS_BITS'(req_size)};
    end else begin
      ram_waddr = SLOT_W'(in_data.slot);
      ram_wdata = {in_data.size, ADDRESS_BITS'(in_data.start_address)};
    end
    // during the scan the read runs one slot ahead of the compare
    if (state == S_SCAN) begin
      ram_raddr = SLOT_W'(cmp_idx + CFG_W'(1));
    end else if (in_data.mode == MODE_ALLOC) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = SLOT_W'(in_data.slot);
    end
  end

  bfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_free_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the response state reloads the output register itself
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_size   <= in_data.size;
            best_found <= 1'b0;
            cmp_idx    <= '0;
            scan_last  <= scan_count - CFG_W'(1);
            case (in_data.mode)
              MODE_LOAD: begin
                res.chosen_slot <= in_data.slot;
                if (in_range) begin
                  res.status          <= ST_DONE;
                  res.granted_address <=
                    ADDR_F_W'(ADDRESS_BITS'(in_data.start_address));
                  res.remaining_size  <= in_data.size;
                end else begin
                  res.status          <= ST_RANGE;
                  res.granted_address <= '0;
                  res.remaining_size  <= '0;
                end
                state <= S_RESP;
              end
              MODE_READ: begin
                // an in-range read gets its status and payload once the ram answers
                res.status          <= ST_RANGE;
                res.chosen_slot     <= in_data.slot;
                res.granted_address <= '0;
                res.remaining_size  <= '0;
                if (in_range) begin
                  state <= S_RDWAIT;
                end else begin
                  state <= S_RESP;
                end
              end
              MODE_ALLOC: begin
                if (scan_count == '0) begin
                  res.status          <= ST_NOFIT;
                  res.chosen_slot     <= '0;
                  res.granted_address <= '0;
                  res.remaining_size  <= '0;
                  state               <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                res.status          <= ST_RANGE;
                res.chosen_slot     <= in_data.slot;
                res.granted_address <= '0;
                res.remaining_size  <= '0;
                state               <= S_RESP;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res.status          <= ST_DONE;
          res.granted_address <= ADDR_F_W'(e_start);
          res.remaining_size  <= e_size;
          state               <= S_RESP;
        end
        S_SCAN: begin
          if (take) begin
            best_found <= 1'b1;
            best_slot  <= cmp_idx;
            best_left  <= e_left;
            best_start <= e_start;
          end
          cmp_idx <= cmp_idx + CFG_W'(1);
          if (cmp_idx == scan_last) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (best_found) begin
            res.status          <= ST_DONE;
            res.chosen_slot     <= SLOT_F_W'(best_slot);
            res.granted_address <= ADDR_F_W'(best_start);
            res.remaining_size  <= best_left;
          end else begin
            res.status          <= ST_NOFIT;
            res.chosen_slot     <= '0;
            res.granted_address <= '0;
            res.remaining_size  <= '0;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != S_IDLE,
                   "accepted word did not start processing")
  `BFA_ASSERT_NOW(a_scan_in_bounds, state == S_SCAN, cmp_idx <= scan_last,
                  "scan index ran past the last slot in use")
  `BFA_ASSERT_NOW(a_write_phase, ram_we, state == S_IDLE || state == S_WB,
                  "free list written outside load or write-back")
  `BFA_ASSERT_NOW(a_best_in_bounds, state == S_WB && best_found, best_slot <= scan_last,
                  "chosen slot lies outside the scanned range")
  `BFA_ASSERT_NOW(a_result_from_resp, $rose(out_valid), $past(state == S_RESP),
                  "result presented without passing the response state")

endmodule

`default_nettype wire

// ===== bench/best_fit_block_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module best_fit_block_allocator_core_tb;
  import bfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_SLOTS = SLOTS_DEFAULT;
  localparam int WORDS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  // free list predictor and store of results still owed by the core
  class free_list_scoreboard;
    logic [SIZE_W-1:0]   free_size [NUM_SLOTS];
    logic [ADDR_F_W-1:0] free_start [NUM_SLOTS];
    logic [CFG_W-1:0]    blocks_in_use = '0;
    bfa_out_t            owed_results [$];
    int errors = 0;
    int loads = 0;
    int reads = 0;
    int grants = 0;
    int no_fits = 0;
    int unused_modes = 0;

    function void set_blocks_in_use(logic [CFG_W-1:0] v);
      blocks_in_use = v;
    endfunction

    function void note_word(bfa_in_t w);
      bfa_out_t r;
      int span;
      bit found;
      logic [SLOT_F_W-1:0] best;
      logic [SIZE_W-1:0] best_left;
      logic [ADDR_F_W-1:0] best_start;
      logic [SIZE_W-1:0] left;
      r = '0;
      case (w.mode)
        MODE_LOAD: begin
          free_size[w.slot] = w.size;
          free_start[w.slot] = w.start_address;
          r.status = ST_DONE;
          r.chosen_slot = w.slot;
          r.granted_address = w.start_address;
          r.remaining_size = w.size;
          loads++;
        end
        MODE_READ: begin
          r.status = ST_DONE;
          r.chosen_slot = w.slot;
          r.granted_address = free_start[w.slot];
          r.remaining_size = free_size[w.slot];
          reads++;
        end
        MODE_ALLOC: begin
          // oversize register values clamp to the table depth
          span = (blocks_in_use > NUM_SLOTS) ? NUM_SLOTS : blocks_in_use;
          found = 1'b0;
          best = '0;
          best_left = '0;
          best_start = '0;
          for (int k = 0; k < span; k++) begin
            if (free_size[k] >= w.size) begin
              left = free_size[k] - w.size;
              if (!found || left < best_left ||
                  (left == best_left && free_start[k] < best_start)) begin
                found = 1'b1;
                best = k[SLOT_F_W-1:0];
                best_left = left;
                best_start = free_start[k];
              end
            end
          end
          if (!found) begin
            r.status = ST_NOFIT;
            no_fits++;
          end else begin
            r.status = ST_DONE;
            r.chosen_slot = best;
            r.granted_address = free_start[best];
            r.remaining_size = best_left;
            free_size[best] = best_left;
            free_start[best] = free_start[best] + w.size;
            grants++;
          end
        end
        default: begin
          r.status = ST_RANGE;
          r.chosen_slot = w.slot;
          unused_modes++;
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_word(bfa_out_t got);
      bfa_out_t want;
      if (owed_results.size() == 0) begin
        $error("result word %h arrived with nothing expected", got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.chosen_slot !== want.chosen_slot) begin
        $error("chosen_slot: expected %0d, got %0d", want.chosen_slot, got.chosen_slot);
        errors++;
      end
      if (got.granted_address !== want.granted_address) begin
        $error("granted_address: expected %h, got %h", want.granted_address,
               got.granted_address);
        errors++;
      end
      if (got.remaining_size !== want.remaining_size) begin
        $error("remaining_size: expected %0d, got %0d", want.remaining_size,
               got.remaining_size);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  bfa_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bfa_out_t out_data;

  free_list_scoreboard sb = new;
  bit no_gaps = 1'b0;
  int settings_used = 0;
  int cycles = 0;

  best_fit_block_allocator_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("best_fit_block_allocator_core test failed");
      $finish;
    end
  end

  function automatic int draw_pause();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic bfa_in_t make_word(logic [MODE_W-1:0] mode, int slot, int size,
                                        int addr);
    bfa_in_t w;
    w.mode = mode;
    w.slot = slot[SLOT_F_W-1:0];
    w.size = size[SIZE_W-1:0];
    w.start_address = addr[ADDR_F_W-1:0];
    return w;
  endfunction

  // every slot is loaded during the opening sequence, so reads and scans never
  // touch an unwritten entry
  function automatic bfa_in_t random_word();
    bfa_in_t w;
    int pick;
    w.slot = SLOT_F_W'($urandom_range(0, 15));
    w.size = SIZE_W'($urandom);
    w.start_address = ADDR_F_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.mode = MODE_ALLOC;
      case ($urandom_range(0, 3))
        0: w.size = SIZE_W'($urandom_range(0, 255));
        1: w.size = SIZE_W'($urandom_range(0, 4095));
        2: w.size = sb.free_size[$urandom_range(0, 15)];
        default: ;
      endcase
    end else if (pick < 70) begin
      w.mode = MODE_LOAD;
      if ($urandom_range(0, 1)) w.size = SIZE_W'($urandom_range(256, 8191));
    end else if (pick < 94) begin
      w.mode = MODE_READ;
    end else begin
      w.mode = MODE_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input bfa_in_t w);
    int gap;
    gap = draw_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.owed_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_blocks_in_use(input int v);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_blocks_in_use(v[CFG_W-1:0]);
    settings_used++;
  endtask

  // result side: random stall before taking each word
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_pause();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_data);
    end
  end

  initial begin
    int phase_counts [8];
    phase_counts = '{16, 31, 1, 0, 17, $urandom_range(2, 15), 8, 16};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty scan range, then the unused mode
    send_word(make_word(MODE_ALLOC, 0, 5, 0));
    send_word(make_word(MODE_UNUSED, 15, 16'hFFFF, 16'hFFFF));
    // extremes, an entry near the top of the address space, and two equal-fit blocks
    send_word(make_word(MODE_LOAD, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 1, 16'hFFFF, 16'hFFFF));
    send_word(make_word(MODE_LOAD, 2, 100, 16'hFFF0));
    send_word(make_word(MODE_LOAD, 3, 100, 16'h1000));
    send_word(make_word(MODE_LOAD, 4, 100, 16'h1000));
    for (int s = 5; s < NUM_SLOTS; s++)
      send_word(make_word(MODE_LOAD, s, 200 + s * 37, s * 16'h0111));
    send_word(make_word(MODE_READ, 1, 0, 0));

    write_blocks_in_use(16);
    send_word(make_word(MODE_ALLOC, 9, 0, 0));
    send_word(make_word(MODE_ALLOC, 0, 16'hFFFF, 0));
    // ties: lower start first, then lower slot, then the wrapping block
    send_word(make_word(MODE_ALLOC, 0, 100, 0));
    send_word(make_word(MODE_ALLOC, 0, 100, 0));
    send_word(make_word(MODE_ALLOC, 0, 100, 0));
    send_word(make_word(MODE_ALLOC, 0, 16'hFFFF, 0));
    send_word(make_word(MODE_READ, 2, 0, 0));

    foreach (phase_counts[p]) begin
      write_blocks_in_use(phase_counts[p]);
      no_gaps = (p == 2 || p == 6);
      repeat (WORDS_PER_PHASE) send_word(random_word());
    end
    no_gaps = 1'b0;

    wait_for_results();
    if (sb.owed_results.size() > 0) begin
      $error("%0d expected results never arrived", sb.owed_results.size());
      sb.errors++;
    end
    $display("run covered %0d loads, %0d reads, %0d grants, %0d no-fit requests,",
             sb.loads, sb.reads, sb.grants, sb.no_fits);
    $display("%0d unused-mode words, over %0d scan-range settings including 0, 16 and oversize",
             sb.unused_modes, settings_used);
    if (sb.errors == 0) begin
      $display("best_fit_block_allocator_core test passed");
    end else begin
      $display("best_fit_block_allocator_core test failed");
    end
    $finish;
  end

endmodule
